// ----- rtl/core/asc_pkg.sv -----
// Shared types and constants for the Annex-B start code splitter.
package asc_pkg;

   localparam logic [7:0] BYTE_ZERO    = 8'h00;
   localparam logic [7:0] BYTE_ONE     = 8'h01;
   localparam logic [2:0] PREFIX_THREE = 3'd3;
   localparam logic [2:0] PREFIX_FOUR  = 3'd4;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_BITS   = 2;

   typedef struct packed {
      logic [31:0] unit_offset;
      logic [31:0] unit_length;
      logic [2:0]  prefix_length;
      logic        stream_final;
      logic        run_last;
   } desc_type;

   typedef struct packed {
      logic [1:0] count;
      desc_type   first;
      desc_type   second;
   } push_type;

endpackage

// ----- rtl/core/annexb_start_code_splitter.sv -----
// Top level of the Annex-B start code splitter.
// Each descriptor is registered into the queue and offered on rsp_ from its head.
// Throughput: one byte per cycle while req_ready is high; a byte closing one unit and
// ending the stream yields two descriptors, drained one per cycle while rsp_ready is
// high, through a four-entry queue. req_ready is high while it holds at most two.
// Reset (synchronous): position, zero run and open unit cleared, queue emptied.
module annexb_start_code_splitter #(
   parameter int POSITION_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_unit_offset,
   output logic [31:0] rsp_unit_length,
   output logic [2:0]  rsp_prefix_length,
   output logic        rsp_stream_final,
   output logic        rsp_run_last
);
   import asc_pkg::*;

   push_type   push;
   desc_type   head;
   logic [2:0] count;
   logic       accept;

   assign req_ready = (count <= 3'd2);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (count != 3'd0);

   asc_scanner #(
      .POSITION_BITS(POSITION_BITS)
   ) u_scanner (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .stream_byte  (req_stream_byte),
      .end_of_stream(req_end_of_stream),
      .push         (push)
   );

   asc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .pop  (rsp_valid && rsp_ready),
      .count(count),
      .head (head)
   );

   assign rsp_unit_offset   = head.unit_offset;
   assign rsp_unit_length   = head.unit_length;
   assign rsp_prefix_length = head.prefix_length;
   assign rsp_stream_final  = head.stream_final;
   assign rsp_run_last      = head.run_last;

endmodule

// ----- rtl/core/asc_scanner.sv -----
// Start code detection, unit tracking and descriptor formation per byte beat.
module asc_scanner #(
   parameter int POSITION_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          stream_byte,
   input  logic                end_of_stream,
   output asc_pkg::push_type   push
);
   import asc_pkg::*;

   localparam int P  = POSITION_BITS;
   localparam int LW = P + 1;
   localparam int EW = (LW > 32) ? LW : 33;

   logic [P-1:0] pos_ff, pos_in;
   logic [1:0]   zero_run_ff, zero_run_in;
   logic         unit_open_ff, unit_open_in;
   logic [P-1:0] open_start_ff, open_start_in;
   logic         open_four_ff, open_four_in;

   logic         start_hit, four, close_v, eos_v;
   logic [P-1:0] start, ustart, close_len;
   logic         ufour;
   logic [LW-1:0] pos_inc, eos_len;
   logic [EW-1:0] off_a_x, len_a_x, off_b_x, len_b_x;
   desc_type     close_d, eos_d;

   function automatic logic [31:0] clamp32(input logic [EW-1:0] v);
      clamp32 = (|v[EW-1:32]) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   always_comb begin
      start_hit = (stream_byte == BYTE_ONE) && zero_run_ff[1];
      four      = (zero_run_ff == 2'd3);
      if (four) begin
         start = (pos_ff >= P'(3)) ? pos_ff - P'(3) : '0;
      end else begin
         start = (pos_ff >= P'(2)) ? pos_ff - P'(2) : '0;
      end
      close_v   = start_hit && unit_open_ff;
      close_len = (start >= open_start_ff) ? start - open_start_ff : '0;
      ustart    = start_hit ? start : open_start_ff;
      ufour     = start_hit ? four : open_four_ff;
      eos_v     = end_of_stream && (unit_open_ff || start_hit);
      pos_inc   = LW'(pos_ff) + LW'(1);
      eos_len   = (LW'(ustart) <= pos_inc) ? pos_inc - LW'(ustart) : '0;

      off_a_x = EW'(open_start_ff);
      len_a_x = EW'(close_len);
      off_b_x = EW'(ustart);
      len_b_x = EW'(eos_len);

      close_d.unit_offset   = clamp32(off_a_x);
      close_d.unit_length   = clamp32(len_a_x);
      close_d.prefix_length = open_four_ff ? PREFIX_FOUR : PREFIX_THREE;
      close_d.stream_final  = 1'b0;
      close_d.run_last      = !eos_v;

      eos_d.unit_offset   = clamp32(off_b_x);
      eos_d.unit_length   = clamp32(len_b_x);
      eos_d.prefix_length = ufour ? PREFIX_FOUR : PREFIX_THREE;
      eos_d.stream_final  = 1'b1;
      eos_d.run_last      = 1'b1;

      push.count  = {1'b0, close_v} + {1'b0, eos_v};
      push.first  = close_v ? close_d : eos_d;
      push.second = eos_d;
      if (!accept) begin
         push.count = 2'd0;
      end

      pos_in        = (&pos_ff) ? pos_ff : pos_inc[P-1:0];
      zero_run_in   = (stream_byte == BYTE_ZERO) ?
                      ((zero_run_ff == 2'd3) ? zero_run_ff : zero_run_ff + 2'd1) : 2'd0;
      unit_open_in  = unit_open_ff || start_hit;
      open_start_in = ustart;
      open_four_in  = ufour;
      if (end_of_stream) begin
         pos_in        = '0;
         zero_run_in   = 2'd0;
         unit_open_in  = 1'b0;
         open_start_in = '0;
         open_four_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         zero_run_ff   <= 2'd0;
         unit_open_ff  <= 1'b0;
         open_start_ff <= '0;
         open_four_ff  <= 1'b0;
      end else if (accept) begin
         pos_ff        <= pos_in;
         zero_run_ff   <= zero_run_in;
         unit_open_ff  <= unit_open_in;
         open_start_ff <= open_start_in;
         open_four_ff  <= open_four_in;
      end
   end

endmodule

// ----- rtl/core/asc_queue.sv -----
// Four-entry descriptor queue taking up to two descriptors per beat.
module asc_queue (
   input  logic                clock,
   input  logic                reset,
   input  asc_pkg::push_type   push,
   input  logic                pop,
   output logic [2:0]          count,
   output asc_pkg::desc_type   head
);
   import asc_pkg::*;

   desc_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0]           count_ff, count_in;
   logic [QPTR_BITS-1:0] wr_next;

   always_comb begin
      wr_next   = wr_ptr_ff + QPTR_BITS'(1);
      wr_ptr_in = wr_ptr_ff + QPTR_BITS'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + 3'(push.count) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   assign count = count_ff;
   assign head  = mem_ff[rd_ptr_ff];

endmodule

// ----- rtl/core/asc_checker.sv -----
// Port-level checks for the Annex-B start code splitter, bound to the top level.
module asc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_unit_offset,
   input logic [31:0] rsp_unit_length,
   input logic [2:0]  rsp_prefix_length,
   input logic        rsp_stream_final,
   input logic        rsp_run_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_unit_offset)
         && $stable(rsp_unit_length))
      else $error("stalled rsp beat changed");

   a_prefix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_prefix_length == 3'd3 || rsp_prefix_length == 3'd4)
      else $error("bad prefix length");

   a_final_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_final |-> rsp_run_last)
      else $error("final descriptor not last of its byte");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind annexb_start_code_splitter asc_checker u_asc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_unit_offset  (rsp_unit_offset),
   .rsp_unit_length  (rsp_unit_length),
   .rsp_prefix_length(rsp_prefix_length),
   .rsp_stream_final (rsp_stream_final),
   .rsp_run_last     (rsp_run_last)
);

// ----- test/nal_descriptor_checker.sv -----
`timescale 1ns / 1ps
// Checker for the start code splitter: predicts unit descriptors from byte beats and compares.
module nal_descriptor_checker #(
   parameter int POS_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_end_of_stream,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_unit_offset,
   input  logic [31:0] rsp_unit_length,
   input  logic [2:0]  rsp_prefix_length,
   input  logic        rsp_stream_final,
   input  logic        rsp_run_last,
   output int          fail_count,
   output int          pending_count
);
   import asc_pkg::*;

   localparam logic [63:0] POS_LIMIT = (64'd1 << POS_BITS) - 64'd1;

   logic [63:0] next_pos;
   logic [63:0] unit_start;
   logic [1:0]  zero_count;
   logic        unit_active;
   logic        unit_four;
   desc_type    due_descriptors[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic logic [31:0] sat32(input logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic logic [63:0] floor_sub(input logic [63:0] a, input logic [63:0] b);
      return (a >= b) ? a - b : 64'd0;
   endfunction

   function automatic desc_type make_desc(input logic [63:0] offset, input logic [63:0] length,
                                          input logic four, input logic last_unit);
      desc_type d;
      d.unit_offset   = sat32(offset);
      d.unit_length   = sat32(length);
      d.prefix_length = four ? PREFIX_FOUR : PREFIX_THREE;
      d.stream_final  = last_unit;
      d.run_last      = 1'b0;
      return d;
   endfunction

   task automatic clear_framing();
      next_pos    = '0;
      unit_start  = '0;
      zero_count  = '0;
      unit_active = 1'b0;
      unit_four   = 1'b0;
   endtask

   task automatic report(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic frame_byte(input logic [7:0] b, input logic eos);
      logic [63:0] pos;
      logic [63:0] start;
      logic        four;
      desc_type    found[2];
      int          n;
      pos = next_pos;
      n   = 0;
      if (b == BYTE_ZERO) begin
         if (zero_count != 2'd3) zero_count++;
      end else begin
         if (b == BYTE_ONE && zero_count >= 2'd2) begin
            four  = (zero_count == 2'd3);
            start = floor_sub(pos, four ? 64'd3 : 64'd2);
            if (unit_active) begin
               found[n] = make_desc(unit_start, floor_sub(start, unit_start), unit_four, 1'b0);
               n++;
            end
            unit_active = 1'b1;
            unit_start  = start;
            unit_four   = four;
         end
         zero_count = '0;
      end
      if (eos) begin
         if (unit_active) begin
            found[n] = make_desc(unit_start, floor_sub(pos + 64'd1, unit_start), unit_four, 1'b1);
            n++;
         end
         clear_framing();
      end else begin
         next_pos = (pos < POS_LIMIT) ? pos + 64'd1 : POS_LIMIT;
      end
      if (n > 0) found[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) due_descriptors.insert(due_descriptors.size(), found[i]);
   endtask

   always @(posedge clock) begin : watch
      desc_type want;
      if (reset) begin
         clear_framing();
         due_descriptors.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_descriptors.size() == 0) begin
               report($sformatf("descriptor with none due, offset %0d length %0d",
                                rsp_unit_offset, rsp_unit_length));
            end else begin
               want = due_descriptors.pop_front();
               if (rsp_unit_offset !== want.unit_offset)
                  report($sformatf("unit_offset %0d, expected %0d",
                                   rsp_unit_offset, want.unit_offset));
               if (rsp_unit_length !== want.unit_length)
                  report($sformatf("unit_length %0d, expected %0d",
                                   rsp_unit_length, want.unit_length));
               if (rsp_prefix_length !== want.prefix_length)
                  report($sformatf("prefix_length %0d, expected %0d",
                                   rsp_prefix_length, want.prefix_length));
               if (rsp_stream_final !== want.stream_final)
                  report($sformatf("stream_final %b, expected %b",
                                   rsp_stream_final, want.stream_final));
               if (rsp_run_last !== want.run_last)
                  report($sformatf("run_last %b, expected %b",
                                   rsp_run_last, want.run_last));
            end
         end
         if (req_valid && req_ready) frame_byte(req_stream_byte, req_end_of_stream);
      end
      pending_count <= due_descriptors.size();
   end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Top of the start code splitter testbench: clock, reset, byte stimulus, stalls and verdict.
module testbench;
   import asc_pkg::*;

   localparam int POS_BITS    = 16;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_ITEMS = 1400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_stream_byte;
   logic        req_end_of_stream;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_unit_offset;
   logic [31:0] rsp_unit_length;
   logic [2:0]  rsp_prefix_length;
   logic        rsp_stream_final;
   logic        rsp_run_last;

   int          fail_count;
   int          pending_count;
   int          items_sent;
   int          send_idle_odds;
   bit          recv_idle_on;
   bit          hold_request;
   bit          hold_done;
   int          quiet_cycles;
   logic [7:0]  stream_q[$];

   annexb_start_code_splitter #(
      .POSITION_BITS(POS_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_stream_byte(req_stream_byte),
      .req_end_of_stream(req_end_of_stream),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_unit_offset(rsp_unit_offset),
      .rsp_unit_length(rsp_unit_length),
      .rsp_prefix_length(rsp_prefix_length),
      .rsp_stream_final(rsp_stream_final),
      .rsp_run_last(rsp_run_last)
   );

   nal_descriptor_checker #(
      .POS_BITS(POS_BITS)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_stream_byte(req_stream_byte),
      .req_end_of_stream(req_end_of_stream),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_unit_offset(rsp_unit_offset),
      .rsp_unit_length(rsp_unit_length),
      .rsp_prefix_length(rsp_prefix_length),
      .rsp_stream_final(rsp_stream_final),
      .rsp_run_last(rsp_run_last),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0, 1, 2: return BYTE_ZERO;
         3:       return BYTE_ONE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic append_byte(input logic [7:0] b);
      stream_q.insert(stream_q.size(), b);
   endtask

   task automatic add_noise(input int n);
      repeat (n) append_byte(pick_byte());
   endtask

   task automatic add_unit(input int max_payload);
      int extra;
      bit four;
      four  = 1'($urandom_range(0, 1));
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (extra + (four ? 3 : 2)) append_byte(BYTE_ZERO);
      append_byte(BYTE_ONE);
      add_noise($urandom_range(0, max_payload));
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eos);
      if (send_idle_odds != 0 && $urandom_range(0, send_idle_odds - 1) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_stream_byte   <= b;
      req_end_of_stream <= eos;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic send_stream();
      foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
      stream_q.delete();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic random_stream();
      case ($urandom_range(0, 9))
         0: add_noise($urandom_range(1, 20));
         1: begin
            add_noise($urandom_range(1, 6));
            append_byte(BYTE_ZERO);
            append_byte(BYTE_ONE);
            add_unit(8);
         end
         default: begin
            if ($urandom_range(0, 2) == 0) add_noise($urandom_range(1, 3));
            repeat ($urandom_range(1, 4)) add_unit(10);
         end
      endcase
      send_stream();
   endtask

   initial begin
      int streams;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_stream_byte   = '0;
      req_end_of_stream = 1'b0;
      items_sent        = 0;
      send_idle_odds    = 4;
      recv_idle_on      = 1'b1;
      hold_request      = 1'b0;
      hold_done         = 1'b0;
      quiet_cycles      = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // no start code at all, then the main prefix shapes, then start code on the last byte
      stream_q = '{8'hFF, 8'h80, 8'h7F};
      send_stream();
      stream_q = '{BYTE_ZERO, BYTE_ZERO, BYTE_ONE, 8'hFF,
                   BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ONE,
                   BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ONE,
                   BYTE_ZERO, BYTE_ZERO, BYTE_ONE};
      send_stream();
      stream_q = '{8'hFE, BYTE_ZERO, BYTE_ZERO, BYTE_ONE};
      send_stream();
      wait_drained();

      streams = 0;
      while (items_sent < RANDOM_ITEMS) begin
         random_stream();
         streams++;
         if (!hold_done && items_sent > 700) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         if (streams % 25 == 0) wait_drained();
      end
      wait_drained();

      send_idle_odds = 0;
      recv_idle_on   = 1'b0;
      repeat (30) random_stream();

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
